[hw/rtl/rc4_pkg.sv]
// Shared types and constants of the RC4 stream cipher engine.
package rc4_pkg;

  localparam int unsigned SBOX_DEPTH = 256;
  localparam int unsigned SBOX_AW    = $clog2(SBOX_DEPTH);
  localparam int unsigned KEY_DEPTH  = 256;
  localparam int unsigned KEY_AW     = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int unsigned CFG_W      = 9;
  localparam int unsigned BYTE_W     = 8;
  localparam logic [CFG_W-1:0] KEY_LEN_RESET = CFG_W'(16);
  localparam logic [CFG_W-1:0] KEY_LEN_MAX   = CFG_W'(KEY_DEPTH);
  localparam logic [BYTE_W-1:0] LAST_IDX     = BYTE_W'(SBOX_DEPTH - 1);

  typedef enum logic [1:0] {
    CMD_WRITE_KEY = 2'd0,
    CMD_SCHEDULE  = 2'd1,
    CMD_CIPHER    = 2'd2,
    CMD_NONE      = 2'd3
  } rc4_cmd_e;

  typedef struct packed {
    rc4_cmd_e          cmd;
    logic [BYTE_W-1:0] key_index;
    logic [BYTE_W-1:0] data_byte;
  } rc4_req_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] cipher_byte;
  } rc4_res_t;

  typedef struct packed {
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] c;
  } rc4_alu_op_t;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_INIT   = 9'b000000010,
    ST_SCH_RD = 9'b000000100,
    ST_SCH_J  = 9'b000001000,
    ST_SCH_WJ = 9'b000010000,
    ST_SCH_WN = 9'b000100000,
    ST_CI_J   = 9'b001000000,
    ST_CI_WJ  = 9'b010000000,
    ST_CI_WI  = 9'b100000000
  } rc4_state_e;

endpackage

[hw/rtl/rc4_stream_cipher.sv]
// RC4 stream cipher engine: key store, key schedule and byte ciphering on streams.
// Each input beat carries a command in s_axis_tuser. A key byte write (and the
// unused command) leaves the engine idle. A key schedule fills the box with the
// identity in ST_INIT, starts the first read in ST_SCH_RD, then runs 256 swap
// steps through ST_SCH_J, ST_SCH_WJ and ST_SCH_WN on the box memory's single read
// and single write port. A data byte passes through ST_CI_J, ST_CI_WJ and
// ST_CI_WI after the accepting beat, with three dependent box reads and two box
// writes; ST_CI_WI holds until the output register is free, and no new beat is
// taken before the engine is idle again. A result waits in an output register
// while the engine takes key writes and schedules. The user must write key_length
// through cfg_we_i only while the engine is idle; the block does not enforce it.
module rc4_stream_cipher
  import rc4_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,   // key_length
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,  // [7:0] key_index, [15:8] data_byte
  input  logic [1:0]       s_axis_tuser,  // [1:0] cmd
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata   // [7:0] cipher_byte
);

  logic [CFG_W-1:0]  key_length_q;
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_data_q;
  rc4_req_t          req;
  rc4_res_t          res;
  logic              res_ready;

  assign req.cmd       = rc4_cmd_e'(s_axis_tuser);
  assign req.key_index = s_axis_tdata[7:0];
  assign req.data_byte = s_axis_tdata[15:8];

  // The output register is free when empty or when its beat leaves this cycle.
  assign res_ready = !out_valid_q || m_axis_tready;

  rc4_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .req_i        (req),
    .key_length_i (key_length_q),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= KEY_LEN_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        key_length_q <= cfg_wdata_i;
      end
      if (res.valid && res_ready) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_data_q <= res.cipher_byte;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[hw/rtl/rc4_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rc4_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // A read and a write to the same address in one cycle return the old data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/rc4_alu.sv]
// Shared three-operand byte adder used for the i, j and keystream index computations.
module rc4_alu
  import rc4_pkg::*;
(
  input  rc4_alu_op_t       op_i,
  output logic [BYTE_W-1:0] sum_o
);

  logic [BYTE_W+1:0] wide_sum;

  assign wide_sum = {2'b00, op_i.a} + {2'b00, op_i.b} + {2'b00, op_i.c};
  assign sum_o    = wide_sum[BYTE_W-1:0];

endmodule

[hw/rtl/rc4_core.sv]
// Sequencer and datapath of the RC4 engine: key store, box memory, indexes.
module rc4_core
  import rc4_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  rc4_req_t         req_i,
  input  logic [CFG_W-1:0] key_length_i,
  output rc4_res_t         res_o,
  input  logic             res_ready_i
);

  rc4_state_e        state_q, state_d;
  logic [BYTE_W-1:0] i_q, i_d, j_q, j_d;
  logic [BYTE_W-1:0] n_q, n_d, jj_q, jj_d;
  logic [CFG_W-1:0]  k_q, k_d, k_inc, eff_len;
  logic [BYTE_W-1:0] si_q, si_d, sj_q, sj_d, t_q, t_d, msg_q, msg_d;

  logic               s_we, s_re, k_we, k_re;
  logic [SBOX_AW-1:0] s_waddr, s_raddr;
  logic [BYTE_W-1:0]  s_wdata, s_rdata, k_rdata;
  logic [KEY_AW-1:0]  k_raddr;
  logic               accept;
  rc4_alu_op_t        alu_op;
  logic [BYTE_W-1:0]  alu_sum;
  logic [BYTE_W-1:0]  keystream;

  rc4_ram #(.Width(BYTE_W), .Depth(SBOX_DEPTH)) u_sbox (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  rc4_ram #(.Width(BYTE_W), .Depth(KEY_DEPTH)) u_key (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .waddr_i (req_i.key_index[KEY_AW-1:0]),
    .wdata_i (req_i.data_byte),
    .re_i    (k_re),
    .raddr_i (k_raddr),
    .rdata_o (k_rdata)
  );

  rc4_alu u_alu (
    .op_i  (alu_op),
    .sum_o (alu_sum)
  );

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign k_we        = accept && (req_i.cmd == CMD_WRITE_KEY) &&
                       ({1'b0, req_i.key_index} < KEY_LEN_MAX);

  assign eff_len = ((key_length_i == '0) || (key_length_i > KEY_LEN_MAX)) ?
                   KEY_LEN_MAX : key_length_i;
  assign k_inc   = ((k_q + CFG_W'(1)) >= eff_len) ? '0 : (k_q + CFG_W'(1));

  // After the swap, the keystream entry may be one of the two just written.
  assign keystream = (t_q == i_q) ? sj_q : ((t_q == j_q) ? si_q : s_rdata);

  assign res_o.valid       = (state_q == ST_CI_WI);
  assign res_o.cipher_byte = msg_q ^ keystream;

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    n_d     = n_q;
    jj_d    = jj_q;
    k_d     = k_q;
    si_d    = si_q;
    sj_d    = sj_q;
    t_d     = t_q;
    msg_d   = msg_q;
    s_we    = 1'b0;
    s_waddr = n_q;
    s_wdata = n_q;
    s_re    = 1'b0;
    s_raddr = n_q;
    k_re    = 1'b0;
    k_raddr = k_q[KEY_AW-1:0];
    alu_op  = '{a: i_q, b: 8'd1, c: 8'd0};
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.cmd)
            CMD_SCHEDULE: begin
              n_d     = '0;
              state_d = ST_INIT;
            end
            CMD_CIPHER: begin
              i_d     = alu_sum;
              s_re    = 1'b1;
              s_raddr = alu_sum;
              msg_d   = req_i.data_byte;
              state_d = ST_CI_J;
            end
            default: ;
          endcase
        end
      end
      ST_INIT: begin
        s_we = 1'b1;
        n_d  = n_q + 8'd1;
        if (n_q == LAST_IDX) begin
          jj_d    = '0;
          k_d     = '0;
          state_d = ST_SCH_RD;
        end
      end
      ST_SCH_RD: begin
        s_re    = 1'b1;
        k_re    = 1'b1;
        state_d = ST_SCH_J;
      end
      ST_SCH_J: begin
        alu_op  = '{a: jj_q, b: s_rdata, c: k_rdata};
        jj_d    = alu_sum;
        si_d    = s_rdata;
        s_re    = 1'b1;
        s_raddr = alu_sum;
        state_d = ST_SCH_WJ;
      end
      ST_SCH_WJ: begin
        sj_d    = s_rdata;
        s_we    = 1'b1;
        s_waddr = jj_q;
        s_wdata = si_q;
        state_d = ST_SCH_WN;
      end
      ST_SCH_WN: begin
        s_we    = 1'b1;
        s_wdata = sj_q;
        n_d     = n_q + 8'd1;
        k_d     = k_inc;
        if (n_q == LAST_IDX) begin
          i_d     = '0;
          j_d     = '0;
          state_d = ST_IDLE;
        end else begin
          // The next read address never equals the entry written this cycle.
          s_re    = 1'b1;
          s_raddr = n_q + 8'd1;
          k_re    = 1'b1;
          k_raddr = k_inc[KEY_AW-1:0];
          state_d = ST_SCH_J;
        end
      end
      ST_CI_J: begin
        alu_op  = '{a: j_q, b: s_rdata, c: 8'd0};
        j_d     = alu_sum;
        si_d    = s_rdata;
        s_re    = 1'b1;
        s_raddr = alu_sum;
        state_d = ST_CI_WJ;
      end
      ST_CI_WJ: begin
        alu_op  = '{a: si_q, b: s_rdata, c: 8'd0};
        sj_d    = s_rdata;
        t_d     = alu_sum;
        s_we    = 1'b1;
        s_waddr = j_q;
        s_wdata = si_q;
        s_re    = 1'b1;
        s_raddr = alu_sum;
        state_d = ST_CI_WI;
      end
      ST_CI_WI: begin
        s_we    = 1'b1;
        s_waddr = i_q;
        s_wdata = sj_q;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      n_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      n_q     <= n_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    jj_q  <= jj_d;
    si_q  <= si_d;
    sj_q  <= sj_d;
    t_q   <= t_d;
    msg_q <= msg_d;
  end

`ifndef SYNTH
  a_sched_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCH_WN && n_q == LAST_IDX) |=>
      (state_q == ST_IDLE && i_q == '0 && j_q == '0))
    else $error("key schedule did not end with cleared indexes");

  a_key_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCH_J || state_q == ST_SCH_WJ || state_q == ST_SCH_WN) |->
      (k_q < eff_len))
    else $error("key position ran past the key length");

  a_cipher_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.cmd == CMD_CIPHER) |=> ##1 (state_q == ST_CI_WJ))
    else $error("cipher sequence skipped a step");

  a_res_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_ready_i) |=> (state_q == ST_IDLE && i_q == $past(i_q)))
    else $error("result beat did not return the engine to idle");
`endif

endmodule
